@@ rtl/usrd_pkg.sv @@
// Shared types and constants for the Unicode string record decoder.
`timescale 1ns / 1ps

package usrd_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MARKER = 2'd1;
    localparam logic [1:0] ERR_TRUNC  = 2'd2;

    localparam logic [7:0]  MARK_FF   = 8'hFF;
    localparam logic [7:0]  MARK_FE   = 8'hFE;
    localparam logic [7:0]  LEN_ESC8  = 8'd255;
    localparam logic [31:0] LEN_ESC16 = 32'd65535;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] error;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        result_t [MAX_RESULTS-1:0]   entry;
    } burst_t;

    typedef struct packed {
        logic [CNT_W-1:0] level;
    } obuf_status_t;

endpackage

@@ rtl/usrd_decode.sv @@
// Record parser state and UTF-16LE to UTF-8 conversion of one input byte.
`timescale 1ns / 1ps

module usrd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  usrd_pkg::item_t  item,
    output usrd_pkg::burst_t burst
);

    typedef enum logic [2:0] {
        PH_MARK0,
        PH_MARK1,
        PH_MARK2,
        PH_LEN8,
        PH_LEN16,
        PH_LEN32,
        PH_UNIT_LO,
        PH_UNIT_HI
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] units_reg, units_next;
    logic [7:0]  low_reg, low_next;

    always_comb
    begin
        logic [7:0]      b;
        logic            fin;
        logic [15:0]     c;
        logic [31:0]     acc;
        logic            body;
        logic [31:0]     body_cnt;
        usrd_pkg::burst_t res;

        b          = item.in_byte;
        fin        = (units_reg <= 32'd1);
        c          = {b, low_reg};
        acc        = '0;
        body       = 1'b0;
        body_cnt   = '0;
        res        = '0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        accum_next = accum_reg;
        units_next = units_reg;
        low_next   = low_reg;

        unique case (phase_reg)
            PH_MARK0, PH_MARK1, PH_MARK2:
            begin
                if (b != ((phase_reg == PH_MARK1) ? usrd_pkg::MARK_FE : usrd_pkg::MARK_FF)
                    || (item.stream_end && phase_reg != PH_MARK2))
                begin
                    phase_next         = PH_MARK0;
                    res.entry[0]       = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                           error: usrd_pkg::ERR_MARKER};
                    res.count          = usrd_pkg::CNT_W'(1);
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
            end
            PH_LEN8:
            begin
                if (b == usrd_pkg::LEN_ESC8)
                begin
                    idx_next   = 2'd0;
                    accum_next = '0;
                    phase_next = PH_LEN16;
                end
                else
                begin
                    body     = 1'b1;
                    body_cnt = {24'd0, b};
                end
            end
            PH_LEN16:
            begin
                acc        = accum_reg | ({24'd0, b} << {idx_reg[0], 3'b000});
                accum_next = acc;
                if (idx_reg[0])
                begin
                    if (acc == usrd_pkg::LEN_ESC16)
                    begin
                        idx_next   = 2'd0;
                        accum_next = '0;
                        phase_next = PH_LEN32;
                    end
                    else
                    begin
                        body     = 1'b1;
                        body_cnt = acc;
                    end
                end
                else
                begin
                    idx_next = 2'd1;
                end
            end
            PH_LEN32:
            begin
                acc        = accum_reg | ({24'd0, b} << {idx_reg, 3'b000});
                accum_next = acc;
                if (idx_reg == 2'd3)
                begin
                    body     = 1'b1;
                    body_cnt = acc;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            PH_UNIT_LO:
            begin
                low_next   = b;
                phase_next = PH_UNIT_HI;
            end
            PH_UNIT_HI:
            begin
                if (c < 16'h0080)
                begin
                    res.entry[0] = '{out_byte: c[7:0], byte_valid: 1'b1, last: fin,
                                     error: usrd_pkg::ERR_NONE};
                    res.count    = usrd_pkg::CNT_W'(1);
                end
                else if (c < 16'h0800)
                begin
                    res.entry[0] = '{out_byte: {3'b110, c[10:6]}, byte_valid: 1'b1,
                                     last: 1'b0, error: usrd_pkg::ERR_NONE};
                    res.entry[1] = '{out_byte: {2'b10, c[5:0]}, byte_valid: 1'b1,
                                     last: fin, error: usrd_pkg::ERR_NONE};
                    res.count    = usrd_pkg::CNT_W'(2);
                end
                else
                begin
                    res.entry[0] = '{out_byte: {4'b1110, c[15:12]}, byte_valid: 1'b1,
                                     last: 1'b0, error: usrd_pkg::ERR_NONE};
                    res.entry[1] = '{out_byte: {2'b10, c[11:6]}, byte_valid: 1'b1,
                                     last: 1'b0, error: usrd_pkg::ERR_NONE};
                    res.entry[2] = '{out_byte: {2'b10, c[5:0]}, byte_valid: 1'b1,
                                     last: fin, error: usrd_pkg::ERR_NONE};
                    res.count    = usrd_pkg::CNT_W'(3);
                end
                if (fin)
                begin
                    units_next = '0;
                    phase_next = PH_MARK0;
                end
                else
                begin
                    units_next = units_reg - 32'd1;
                    phase_next = PH_UNIT_LO;
                end
            end
            default:
            begin
                phase_next = PH_MARK0;
            end
        endcase

        if (body)
        begin
            if (body_cnt == 32'd0)
            begin
                phase_next   = PH_MARK0;
                res.entry[0] = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                 error: usrd_pkg::ERR_NONE};
                res.count    = usrd_pkg::CNT_W'(1);
            end
            else
            begin
                units_next = body_cnt;
                phase_next = PH_UNIT_LO;
            end
        end

        // stream ended inside a record: flag it after any bytes of this step
        if (item.stream_end && phase_next != PH_MARK0)
        begin
            phase_next                = PH_MARK0;
            res.entry[res.count[1:0]] = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                          error: usrd_pkg::ERR_TRUNC};
            res.count                 = res.count + usrd_pkg::CNT_W'(1);
        end

        burst = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MARK0;
            idx_reg   <= '0;
            accum_reg <= '0;
            units_reg <= '0;
            low_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            accum_reg <= accum_next;
            units_reg <= units_next;
            low_reg   <= low_next;
        end
    end

endmodule

@@ rtl/usrd_obuf.sv @@
// Result register: holds the results of one input byte and sends them one per cycle while result_ready is high.
`timescale 1ns / 1ps

module usrd_obuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  usrd_pkg::burst_t       burst,
    output logic                   load_ready,
    output logic                   result_valid,
    input  logic                   result_ready,
    output usrd_pkg::result_t      result,
    output usrd_pkg::obuf_status_t status
);

    logic [usrd_pkg::CNT_W-1:0]                  cnt_reg;
    usrd_pkg::result_t [usrd_pkg::MAX_RESULTS-1:0] entry_reg;
    logic                                        xfer;

    assign result_valid = (cnt_reg != '0);
    assign result       = entry_reg[0];
    assign xfer         = result_valid && result_ready;
    assign load_ready   = (cnt_reg == '0)
                          || (cnt_reg == usrd_pkg::CNT_W'(1) && result_ready);
    assign status.level = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst.count;
        end
        else if (xfer)
        begin
            cnt_reg <= cnt_reg - usrd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= burst.entry;
        end
        else if (xfer)
        begin
            for (int i = 0; i < usrd_pkg::MAX_RESULTS - 1; i++)
            begin
                entry_reg[i] <= entry_reg[i+1];
            end
            entry_reg[usrd_pkg::MAX_RESULTS-1] <= '0;
        end
    end

endmodule

@@ rtl/unicode_string_record_decoder_top.sv @@
// Top level of the Unicode string record decoder (UTF-16LE record to UTF-8 bytes).
`timescale 1ns / 1ps

// One input byte is taken per transfer and decoded in the same cycle into up to four
// results (three UTF-8 bytes plus a status), which are loaded into a result register
// and leave through the single output port at one result per cycle while result_ready
// is high. A byte that completes a code unit yields one result per UTF-8 byte (one to
// three, plus a status if the stream ends there). The next byte is taken in the same
// cycle as the last pending result transfers, or at once when the register is empty,
// so throughput is limited by the one-result-per-cycle output port. After reset the
// result register is empty and a byte can be taken at once.

module unicode_string_record_decoder_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  usrd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output usrd_pkg::result_t result
);

    usrd_pkg::burst_t       burst;
    usrd_pkg::obuf_status_t obuf_status;
    logic                   take;

    assign take = item_valid && item_ready;

    usrd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .burst (burst)
    );

    usrd_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take),
        .burst        (burst),
        .load_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .status       (obuf_status)
    );

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error != usrd_pkg::ERR_NONE |-> !result.byte_valid && result.last)
        else $error("error result carries a byte or is not last");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_status.level > usrd_pkg::CNT_W'(1) |-> !item_ready)
        else $error("input taken while several results still pending");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> burst.count <= usrd_pkg::CNT_W'(usrd_pkg::MAX_RESULTS))
        else $error("too many results for one input byte");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && obuf_status.level == usrd_pkg::CNT_W'(1) && !take
        |=> !result_valid)
        else $error("result register not empty after last transfer");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the UTF-16LE string record to UTF-8 decoder.
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic [2:0] {
        S_MARK0, S_MARK1, S_MARK2, S_LEN8, S_LEN16, S_LEN32, S_UNIT_LO, S_UNIT_HI
    } dec_phase_t;

    typedef enum int {LEN_FORM8, LEN_FORM16, LEN_FORM32} len_form_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    usrd_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    usrd_pkg::result_t result;

    unicode_string_record_decoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    usrd_pkg::item_t   stream_bytes[$];
    usrd_pkg::result_t utf8_expected[$];
    int                mismatch_count = 0;
    int                send_gap_pct   = 0;
    int                stall_pct      = 0;

    // decoder state as seen by the predictor
    dec_phase_t  dec_phase  = S_MARK0;
    logic [1:0]  len_idx    = '0;
    logic [31:0] len_acc    = '0;
    logic [31:0] units_left = '0;
    logic [7:0]  low_byte   = '0;

    function automatic void push_utf8(logic [7:0] b, logic v, logic l, logic [1:0] e);
        usrd_pkg::result_t r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.last        = l;
        r.error       = e;
        utf8_expected = {utf8_expected, r};
    endfunction

    function automatic void open_body(logic [31:0] count);
        if (count == 0)
        begin
            dec_phase = S_MARK0;
            push_utf8(8'h00, 1'b0, 1'b1, usrd_pkg::ERR_NONE);
        end
        else
        begin
            units_left = count;
            dec_phase  = S_UNIT_LO;
        end
    endfunction

    function automatic void transcode_byte(usrd_pkg::item_t it);
        logic [7:0]  b;
        logic [7:0]  want;
        logic [15:0] cu;
        logic        fin;
        b = it.in_byte;
        case (dec_phase)
            S_MARK0, S_MARK1, S_MARK2:
            begin
                want = (dec_phase == S_MARK1) ? usrd_pkg::MARK_FE : usrd_pkg::MARK_FF;
                if (b != want || (it.stream_end && dec_phase != S_MARK2))
                begin
                    dec_phase = S_MARK0;
                    push_utf8(8'h00, 1'b0, 1'b1, usrd_pkg::ERR_MARKER);
                    return;
                end
                dec_phase = (dec_phase == S_MARK0) ? S_MARK1 :
                            (dec_phase == S_MARK1) ? S_MARK2 : S_LEN8;
            end
            S_LEN8:
            begin
                if (b == usrd_pkg::LEN_ESC8)
                begin
                    len_idx   = '0;
                    len_acc   = '0;
                    dec_phase = S_LEN16;
                end
                else
                    open_body({24'd0, b});
            end
            S_LEN16:
            begin
                len_acc |= {24'd0, b} << (8 * len_idx[0]);
                if (len_idx[0])
                begin
                    if (len_acc == usrd_pkg::LEN_ESC16)
                    begin
                        len_idx   = '0;
                        len_acc   = '0;
                        dec_phase = S_LEN32;
                    end
                    else
                        open_body(len_acc);
                end
                else
                    len_idx = 2'd1;
            end
            S_LEN32:
            begin
                len_acc |= {24'd0, b} << (8 * len_idx);
                if (len_idx == 2'd3)
                    open_body(len_acc);
                else
                    len_idx = len_idx + 2'd1;
            end
            S_UNIT_LO:
            begin
                low_byte  = b;
                dec_phase = S_UNIT_HI;
            end
            default:
            begin
                cu  = {b, low_byte};
                fin = (units_left <= 1);
                if (cu < 16'h0080)
                    push_utf8(cu[7:0], 1'b1, fin, usrd_pkg::ERR_NONE);
                else if (cu < 16'h0800)
                begin
                    push_utf8({3'b110, cu[10:6]}, 1'b1, 1'b0, usrd_pkg::ERR_NONE);
                    push_utf8({2'b10, cu[5:0]}, 1'b1, fin, usrd_pkg::ERR_NONE);
                end
                else
                begin
                    push_utf8({4'b1110, cu[15:12]}, 1'b1, 1'b0, usrd_pkg::ERR_NONE);
                    push_utf8({2'b10, cu[11:6]}, 1'b1, 1'b0, usrd_pkg::ERR_NONE);
                    push_utf8({2'b10, cu[5:0]}, 1'b1, fin, usrd_pkg::ERR_NONE);
                end
                if (fin)
                begin
                    units_left = '0;
                    dec_phase  = S_MARK0;
                end
                else
                begin
                    units_left = units_left - 32'd1;
                    dec_phase  = S_UNIT_LO;
                end
            end
        endcase
        if (it.stream_end && dec_phase != S_MARK0)
        begin
            dec_phase = S_MARK0;
            push_utf8(8'h00, 1'b0, 1'b1, usrd_pkg::ERR_TRUNC);
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic e = 1'b0);
        stream_bytes = {stream_bytes, usrd_pkg::item_t'({b, e})};
    endfunction

    function automatic logic [15:0] rand_unit();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(16'h007F, 16'h0000));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
            default: return 16'($urandom_range(16'hDFFF, 16'hD800));
        endcase
    endfunction

    // Queues one record; end_at >= 0 puts stream_end on that byte and drops the rest.
    function automatic int queue_record(len_form_t form, logic [31:0] count, int n_units,
                                        int end_at);
        usrd_pkg::item_t rec[$];
        logic [15:0]     u;
        rec = {rec, usrd_pkg::item_t'({usrd_pkg::MARK_FF, 1'b0})};
        rec = {rec, usrd_pkg::item_t'({usrd_pkg::MARK_FE, 1'b0})};
        rec = {rec, usrd_pkg::item_t'({usrd_pkg::MARK_FF, 1'b0})};
        case (form)
            LEN_FORM8:
                rec = {rec, usrd_pkg::item_t'({count[7:0], 1'b0})};
            LEN_FORM16:
            begin
                rec = {rec, usrd_pkg::item_t'({usrd_pkg::LEN_ESC8, 1'b0})};
                rec = {rec, usrd_pkg::item_t'({count[7:0], 1'b0})};
                rec = {rec, usrd_pkg::item_t'({count[15:8], 1'b0})};
            end
            default:
            begin
                rec = {rec, usrd_pkg::item_t'({usrd_pkg::LEN_ESC8, 1'b0})};
                rec = {rec, usrd_pkg::item_t'({8'hFF, 1'b0})};
                rec = {rec, usrd_pkg::item_t'({8'hFF, 1'b0})};
                for (int i = 0; i < 4; i++)
                    rec = {rec, usrd_pkg::item_t'({count[8*i +: 8], 1'b0})};
            end
        endcase
        for (int i = 0; i < n_units; i++)
        begin
            u   = rand_unit();
            rec = {rec, usrd_pkg::item_t'({u[7:0], 1'b0})};
            rec = {rec, usrd_pkg::item_t'({u[15:8], 1'b0})};
        end
        if (end_at >= 0)
        begin
            if (end_at >= rec.size())
                end_at = rec.size() - 1;
            while (rec.size() > end_at + 1)
                void'(rec.pop_back());
            rec[end_at].stream_end = 1'b1;
        end
        foreach (rec[i])
            stream_bytes = {stream_bytes, rec[i]};
        return rec.size();
    endfunction

    function automatic void queue_random_traffic(int budget);
        int          used;
        int          pick;
        int          n;
        int          hdr;
        int          end_at;
        logic [7:0]  b;
        logic [31:0] count;
        len_form_t   form;
        used = 0;
        while (used < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                n    = $urandom_range(6);
                pick = $urandom_range(99);
                form = (pick < 60) ? LEN_FORM8 : (pick < 85) ? LEN_FORM16 : LEN_FORM32;
                hdr  = (form == LEN_FORM8) ? 4 : (form == LEN_FORM16) ? 6 : 10;
                count = 32'(n);
                end_at = -1;
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    // declared length beyond what follows, cut short
                    count = (form == LEN_FORM8)  ? $urandom_range(254, 7) :
                            (form == LEN_FORM16) ? $urandom_range(16'hFFFE, 7) :
                                                   $urandom_range(32'hFFFF_FFFF, 7);
                    end_at = hdr + 2 * n - 1;
                end
                else if (pick < 25)
                    end_at = $urandom_range(hdr + 2 * n - 1);
                else if (pick < 35)
                    end_at = hdr + 2 * n - 1;
                used += queue_record(form, count, n, end_at);
            end
            else if (pick < 85)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        b = 8'($urandom_range(255));
                        if (b == usrd_pkg::MARK_FE)
                            b = 8'h00;
                        queue_byte(usrd_pkg::MARK_FF);
                        queue_byte(b, 1'($urandom_range(1)));
                        used += 2;
                    end
                    1:
                    begin
                        b = 8'($urandom_range(255));
                        if (b == usrd_pkg::MARK_FF)
                            b = 8'h7E;
                        queue_byte(usrd_pkg::MARK_FF);
                        queue_byte(usrd_pkg::MARK_FE);
                        queue_byte(b, 1'($urandom_range(1)));
                        used += 3;
                    end
                    default:
                        used += queue_record(LEN_FORM8, 32'd1, 1, $urandom_range(3));
                endcase
            end
            else
            begin
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++)
                    queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                used += n;
            end
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                transcode_byte(item);
            if (!item_valid || item_ready)
            begin
                if (stream_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    item       <= stream_bytes.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        usrd_pkg::result_t due;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (utf8_expected.size() == 0)
                begin
                    $error("unexpected result transfer %p", result);
                    mismatch_count++;
                end
                else
                begin
                    due = utf8_expected.pop_front();
                    if (result.out_byte !== due.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               due.out_byte, result.out_byte);
                        mismatch_count++;
                    end
                    if (result.byte_valid !== due.byte_valid)
                    begin
                        $error("byte_valid: expected %0b, got %0b",
                               due.byte_valid, result.byte_valid);
                        mismatch_count++;
                    end
                    if (result.last !== due.last)
                    begin
                        $error("last: expected %0b, got %0b", due.last, result.last);
                        mismatch_count++;
                    end
                    if (result.error !== due.error)
                    begin
                        $error("error: expected %0d, got %0d", due.error, result.error);
                        mismatch_count++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (stream_bytes.size() != 0 || item_valid || utf8_expected.size() != 0);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty record
        queue_byte(usrd_pkg::MARK_FF); queue_byte(usrd_pkg::MARK_FE);
        queue_byte(usrd_pkg::MARK_FF); queue_byte(8'h00);
        // zero, top one-byte and 0xFFFF units; stream_end on the completing byte
        queue_byte(usrd_pkg::MARK_FF); queue_byte(usrd_pkg::MARK_FE);
        queue_byte(usrd_pkg::MARK_FF); queue_byte(8'h03);
        queue_byte(8'h00); queue_byte(8'h00);
        queue_byte(8'h7F); queue_byte(8'h00);
        queue_byte(8'hFF); queue_byte(8'hFF, 1'b1);
        // stray byte on an idle block, stream ending there
        queue_byte(8'h00, 1'b1);
        // bad third marker byte
        queue_byte(usrd_pkg::MARK_FF); queue_byte(usrd_pkg::MARK_FE); queue_byte(8'h12);
        // stream ends inside the marker
        queue_byte(usrd_pkg::MARK_FF, 1'b1);
        // two-byte unit, then stream ends in the middle of the next unit
        queue_byte(usrd_pkg::MARK_FF); queue_byte(usrd_pkg::MARK_FE);
        queue_byte(usrd_pkg::MARK_FF); queue_byte(8'h05);
        queue_byte(8'h80); queue_byte(8'h00);
        queue_byte(8'hD8, 1'b1);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            send_gap_pct = (p == 1) ? 47 : (p == 3) ? 33 : 0;
            stall_pct    = (p == 2) ? 47 : (p == 3) ? 33 : 0;
            queue_random_traffic(30);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && utf8_expected.size() == 0)
            $display("unicode_string_record_decoder_top test passed");
        else
            $display("unicode_string_record_decoder_top test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("unicode_string_record_decoder_top test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/usrd_pkg.sv
rtl/usrd_decode.sv
rtl/usrd_obuf.sv
rtl/unicode_string_record_decoder_top.sv
verif/tb_top.sv
